>>> rtl/mmb_pkg.sv
// ----------------------------------------------------------------------------
// mmb_pkg
// Constants and helpers for the model matrix builder.
// ----------------------------------------------------------------------------
package mmb_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DEG_FULL      = 23040;
    localparam int DEG_QUAD      = 5760;
    localparam int CORDIC_STEPS  = 16;
    localparam int CORDIC_GAIN   = 652032874;

    // atan(2^-i) in degrees * 65536
    function automatic logic signed [23:0] atan_deg(input logic [3:0] i);
        logic signed [23:0] v;
        unique case (i)
            4'd0:  v = 24'sd2949120;
            4'd1:  v = 24'sd1740967;
            4'd2:  v = 24'sd919879;
            4'd3:  v = 24'sd466945;
            4'd4:  v = 24'sd234379;
            4'd5:  v = 24'sd117304;
            4'd6:  v = 24'sd58666;
            4'd7:  v = 24'sd29335;
            4'd8:  v = 24'sd14668;
            4'd9:  v = 24'sd7334;
            4'd10: v = 24'sd3667;
            4'd11: v = 24'sd1833;
            4'd12: v = 24'sd917;
            4'd13: v = 24'sd458;
            4'd14: v = 24'sd229;
            default: v = 24'sd115;
        endcase
        return v;
    endfunction

    // 64-bit signed value saturated to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/model_matrix_builder_top.sv
// ----------------------------------------------------------------------------
// model_matrix_builder_top
// Builds M = T * S * (Rz * Ry * Rx) per pose and sends it as four rows.
// ----------------------------------------------------------------------------
// Each pose passes sincos, P1, P2 and P3 into the row buffer, which sends its four
// rows one a cycle while i_stall is low; this serializer sets the pose rate.
// The sine/cosine and product pipeline advances as a whole; stall freezes it.
// Reset: synchronous active low clears valid bits and the row counter.
module model_matrix_builder_top #(
    parameter int FRAC_BITS = mmb_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [31:0] i_scl_x,
    input  logic signed [31:0] i_scl_y,
    input  logic signed [31:0] i_scl_z,
    input  logic signed [15:0] i_angle_x,
    input  logic signed [15:0] i_angle_y,
    input  logic signed [15:0] i_angle_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_row_index,
    output logic signed [31:0] o_col0,
    output logic signed [31:0] o_col1,
    output logic signed [31:0] o_col2,
    output logic signed [31:0] o_col3,
    output logic               o_last_row
);

    localparam int SC_LAT = mmb_pkg::CORDIC_STEPS + 3;
    localparam int LAT    = SC_LAT + 3;

    // pipeline: sincos (SC_LAT), P1 two-products, P2 three-products, P3 rot30,
    // then the row buffer, which scales its 3 rotation rows one by one
    logic w_adv;
    logic [1:0] r_row;
    logic r_pend;
    logic [LAT-1:0] r_vld;
    logic w_take;
    logic w_out_free;

    assign w_out_free = !o_valid || !i_stall;

    // buffer reloads while its last row word leaves
    assign w_take = r_vld[LAT-1] && (!r_pend || (w_out_free && r_row == 2'd3));

    // pipeline stalls only when a finished pose cannot move into the buffer
    assign w_adv   = !r_vld[LAT-1] || w_take;
    assign o_stall = !w_adv;

    logic signed [15:0] w_sx, w_cx, w_sy, w_cy, w_sz, w_cz;

    mmb_sincos u_sx (.i_clk, .i_en(w_adv), .i_angle(i_angle_x), .o_sin(w_sx), .o_cos(w_cx));
    mmb_sincos u_sy (.i_clk, .i_en(w_adv), .i_angle(i_angle_y), .o_sin(w_sy), .o_cos(w_cy));
    mmb_sincos u_sz (.i_clk, .i_en(w_adv), .i_angle(i_angle_z), .o_sin(w_sz), .o_cos(w_cz));

    // pos/scale delay line
    logic signed [31:0] r_pd [LAT][6];
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pd[0][0] <= i_pos_x;
            r_pd[0][1] <= i_pos_y;
            r_pd[0][2] <= i_pos_z;
            r_pd[0][3] <= i_scl_x;
            r_pd[0][4] <= i_scl_y;
            r_pd[0][5] <= i_scl_z;
            for (int k = 1; k < LAT; k++) begin
                r_pd[k] <= r_pd[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // P1: pairwise products, Q.28
    logic signed [31:0] r_czcy, r_szcy, r_czsy, r_szsy, r_sx1, r_cx1, r_szcx, r_czcx;
    logic signed [31:0] r_szsx, r_czsx, r_sy1, r_cysx, r_cycx;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_czcy <= 32'(w_cz) * 32'(w_cy);
            r_szcy <= 32'(w_sz) * 32'(w_cy);
            r_czsy <= 32'(w_cz) * 32'(w_sy);
            r_szsy <= 32'(w_sz) * 32'(w_sy);
            r_szcx <= 32'(w_sz) * 32'(w_cx);
            r_czcx <= 32'(w_cz) * 32'(w_cx);
            r_szsx <= 32'(w_sz) * 32'(w_sx);
            r_czsx <= 32'(w_cz) * 32'(w_sx);
            r_cysx <= 32'(w_cy) * 32'(w_sx);
            r_cycx <= 32'(w_cy) * 32'(w_cx);
            r_sx1  <= 32'(w_sx);
            r_cx1  <= 32'(w_cx);
            r_sy1  <= 32'(w_sy);
        end
    end

    // P2: elements in Q.42
    logic signed [47:0] r_e [9];
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_e[0] <= 48'(r_czcy) <<< 14;
            r_e[1] <= 48'(r_czsy) * 48'(r_sx1) - (48'(r_szcx) <<< 14);
            r_e[2] <= 48'(r_czsy) * 48'(r_cx1) + (48'(r_szsx) <<< 14);
            r_e[3] <= 48'(r_szcy) <<< 14;
            r_e[4] <= 48'(r_szsy) * 48'(r_sx1) + (48'(r_czcx) <<< 14);
            r_e[5] <= 48'(r_szsy) * 48'(r_cx1) - (48'(r_czsx) <<< 14);
            r_e[6] <= -(48'(r_sy1) <<< 28);
            r_e[7] <= 48'(r_cysx) <<< 14;
            r_e[8] <= 48'(r_cycx) <<< 14;
        end
    end

    // P3: round to Q.30
    logic signed [35:0] r_r [9];
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < 9; k++) begin
                r_r[k] <= 36'((r_e[k] + 48'sd2048) >>> 12);
            end
        end
    end

    // output side: row buffer, one multiply row per cycle while the output is free
    logic signed [35:0] r_br [9];
    logic signed [31:0] r_bs [3];
    logic signed [31:0] r_bp [3];
    logic signed [67:0] w_pr [3];

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_br <= r_r;
            for (int k = 0; k < 3; k++) begin
                r_bp[k] <= r_pd[LAT-1][k];
                r_bs[k] <= r_pd[LAT-1][3+k];
            end
        end
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_pr[j] = 68'sd0;
        end
        if (r_row != 2'd3) begin
            for (int j = 0; j < 3; j++) begin
                w_pr[j] = ((68'(r_bs[r_row]) * 68'(r_br[3*r_row+j])) + (68'sd1 <<< 29)) >>> 30;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= 1'b0;
            r_row   <= 2'd0;
            o_valid <= 1'b0;
        end else begin
            if (w_out_free) begin
                o_valid <= r_pend;
                if (r_pend) begin
                    r_row <= r_row + 2'd1;
                    if (r_row == 2'd3 && !w_take) begin
                        r_pend <= 1'b0;
                    end
                end
            end
            if (w_take) begin
                r_pend <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && r_pend) begin
            o_row_index <= r_row;
            o_last_row  <= (r_row == 2'd3);
            if (r_row == 2'd3) begin
                o_col0 <= '0;
                o_col1 <= '0;
                o_col2 <= '0;
                o_col3 <= 32'(64'sd1 <<< FRAC_BITS);
            end else begin
                o_col0 <= mmb_pkg::sat32(64'(w_pr[0]));
                o_col1 <= mmb_pkg::sat32(64'(w_pr[1]));
                o_col2 <= mmb_pkg::sat32(64'(w_pr[2]));
                o_col3 <= r_bp[r_row];
            end
        end
    end

endmodule

>>> rtl/mmb_sincos.sv
// ----------------------------------------------------------------------------
// mmb_sincos
// Pipelined angle reduction and 16-step CORDIC; Q1.14 sine and cosine.
// One stage per CORDIC step, two stages for reduction, one for rounding.
// ----------------------------------------------------------------------------
module mmb_sincos (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [15:0] i_angle,
    output logic signed [15:0] o_sin,
    output logic signed [15:0] o_cos
);

    localparam int NS = mmb_pkg::CORDIC_STEPS;

    // reduction: stage A mod 23040, stage B quadrant split
    logic [14:0] r_red;
    logic [14:0] n_red;
    logic [1:0]  r_q0;
    logic [12:0] r_a;
    logic signed [17:0] w_m;

    always_comb begin
        // angle + 2*23040 is in 13312..78847; subtract up to three times 23040
        w_m = 18'(i_angle) + 18'sd46080;
        if (w_m >= 18'sd69120) begin
            n_red = 15'(w_m - 18'sd69120);
        end else if (w_m >= 18'sd46080) begin
            n_red = 15'(w_m - 18'sd46080);
        end else if (w_m >= 18'sd23040) begin
            n_red = 15'(w_m - 18'sd23040);
        end else begin
            n_red = 15'(w_m);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_red <= n_red;
            if (r_red >= 15'd17280) begin
                r_q0 <= 2'd3;
                r_a  <= 13'(r_red - 15'd17280);
            end else if (r_red >= 15'd11520) begin
                r_q0 <= 2'd2;
                r_a  <= 13'(r_red - 15'd11520);
            end else if (r_red >= 15'd5760) begin
                r_q0 <= 2'd1;
                r_a  <= 13'(r_red - 15'd5760);
            end else begin
                r_q0 <= 2'd0;
                r_a  <= 13'(r_red);
            end
        end
    end

    logic signed [31:0] r_x [NS+1];
    logic signed [31:0] r_y [NS+1];
    logic signed [24:0] r_z [NS+1];
    logic [1:0]         r_q [NS+1];

    always_comb begin
        r_x[0] = 32'(mmb_pkg::CORDIC_GAIN);
        r_y[0] = '0;
        r_z[0] = 25'({r_a, 10'd0});
        r_q[0] = r_q0;
    end

    for (genvar g = 0; g < NS; g++) begin : g_step
        logic signed [31:0] r_xs;
        logic signed [31:0] r_ys;
        logic signed [24:0] r_zs;
        logic [1:0]         r_qs;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_qs <= r_q[g];
                if (r_z[g] >= 0) begin
                    r_xs <= r_x[g] - (r_y[g] >>> g);
                    r_ys <= r_y[g] + (r_x[g] >>> g);
                    r_zs <= r_z[g] - 25'(mmb_pkg::atan_deg(4'(g)));
                end else begin
                    r_xs <= r_x[g] + (r_y[g] >>> g);
                    r_ys <= r_y[g] - (r_x[g] >>> g);
                    r_zs <= r_z[g] + 25'(mmb_pkg::atan_deg(4'(g)));
                end
            end
        end
        assign r_x[g+1] = r_xs;
        assign r_y[g+1] = r_ys;
        assign r_z[g+1] = r_zs;
        assign r_q[g+1] = r_qs;
    end

    logic signed [31:0] w_cr;
    logic signed [31:0] w_sr;
    logic signed [15:0] w_c;
    logic signed [15:0] w_s;

    always_comb begin
        w_cr = (r_x[NS] + 32'sd32768) >>> 16;
        w_sr = (r_y[NS] + 32'sd32768) >>> 16;
        w_c  = (w_cr < 0) ? 16'sd0 : ((w_cr > 32'sd16384) ? 16'sd16384 : 16'(w_cr));
        w_s  = (w_sr < 0) ? 16'sd0 : ((w_sr > 32'sd16384) ? 16'sd16384 : 16'(w_sr));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            unique case (r_q[NS])
                2'd0: begin o_sin <= w_s;  o_cos <= w_c;  end
                2'd1: begin o_sin <= w_c;  o_cos <= -w_s; end
                2'd2: begin o_sin <= -w_s; o_cos <= -w_c; end
                default: begin o_sin <= -w_c; o_cos <= w_s; end
            endcase
        end
    end

endmodule

>>> dv/tb_model_matrix_builder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_model_matrix_builder_top
// Drives random and corner-case poses into the model matrix builder and
// checks every output row against a predicted 4x4 model matrix.
// ----------------------------------------------------------------------------
module tb_model_matrix_builder_top;

    localparam int FRAC   = mmb_pkg::FRAC_BITS_DEF;
    localparam int WDOG   = 20000;

    typedef struct {
        logic signed [31:0] pos [3];
        logic signed [31:0] scl [3];
        logic signed [15:0] ang [3];
    } pose_t;

    typedef struct {
        logic [1:0]         row;
        logic signed [31:0] col [4];
        logic               last;
    } row_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [31:0] i_pos_x = '0, i_pos_y = '0, i_pos_z = '0;
    logic signed [31:0] i_scl_x = '0, i_scl_y = '0, i_scl_z = '0;
    logic signed [15:0] i_angle_x = '0, i_angle_y = '0, i_angle_z = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [1:0]         o_row_index;
    logic signed [31:0] o_col0, o_col1, o_col2, o_col3;
    logic               o_last_row;

    pose_t pending_poses[$];
    row_t  expected_rows[$];
    int    mismatches = 0;
    int    idle_cycles = 0;

    model_matrix_builder_top i_dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic longint asr64(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint rnd_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp64(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic logic signed [31:0] sat_word(longint v);
        return 32'(clamp64(v, -64'sd2147483648, 64'sd2147483647));
    endfunction

    function automatic void trig_q14(logic signed [15:0] ang,
                                     output longint sn, output longint cs);
        longint atan_tab [16] = '{2949120, 1740967, 919879, 466945, 234379,
            117304, 58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};
        longint r, q, x, y, z, nx, c0, s0;
        r = longint'(ang) % 23040;
        if (r < 0) r += 23040;
        q = r / 5760;
        x = 652032874;
        y = 0;
        z = (r - q * 5760) * 1024;
        for (int i = 0; i < 16; i++) begin
            if (z >= 0) begin
                nx = x - asr64(y, i);
                y = y + asr64(x, i);
                z -= atan_tab[i];
            end else begin
                nx = x + asr64(y, i);
                y = y - asr64(x, i);
                z += atan_tab[i];
            end
            x = nx;
        end
        c0 = clamp64(rnd_shift(x, 16), 0, 16384);
        s0 = clamp64(rnd_shift(y, 16), 0, 16384);
        case (q)
            0: begin sn = s0;  cs = c0;  end
            1: begin sn = c0;  cs = -s0; end
            2: begin sn = -s0; cs = -c0; end
            default: begin sn = -c0; cs = s0; end
        endcase
    endfunction

    function automatic void predict_matrix(pose_t p);
        longint sx, cx, sy, cy, sz, cz;
        longint rot [3][3];
        longint k = 16384;
        row_t r;
        trig_q14(p.ang[0], sx, cx);
        trig_q14(p.ang[1], sy, cy);
        trig_q14(p.ang[2], sz, cz);
        rot[0][0] = cz * cy * k;
        rot[0][1] = cz * sy * sx - sz * cx * k;
        rot[0][2] = cz * sy * cx + sz * sx * k;
        rot[1][0] = sz * cy * k;
        rot[1][1] = sz * sy * sx + cz * cx * k;
        rot[1][2] = sz * sy * cx - cz * sx * k;
        rot[2][0] = -sy * k * k;
        rot[2][1] = cy * sx * k;
        rot[2][2] = cy * cx * k;
        for (int i = 0; i < 3; i++) begin
            r.row = 2'(i);
            for (int j = 0; j < 3; j++)
                r.col[j] = sat_word(rnd_shift(longint'(p.scl[i]) *
                                              rnd_shift(rot[i][j], 12), 30));
            r.col[3] = p.pos[i];
            r.last = 1'b0;
            expected_rows.push_back(r);
        end
        r.row = 2'd3;
        r.col = '{0, 0, 0, sat_word(longint'(1) <<< FRAC)};
        r.last = 1'b1;
        expected_rows.push_back(r);
    endfunction

    function automatic logic signed [31:0] rand_q16();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $signed($urandom_range(0, 131072)) - 65536;
            2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed($urandom_range(0, 1048576)) - 524288;
        endcase
    endfunction

    function automatic logic signed [15:0] rand_angle();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'(5760 * $signed($urandom_range(0, 8)) - 23040);
            default: return 16'($signed($urandom_range(0, 46080)) - 23040);
        endcase
    endfunction

    // driver: bursts with random gaps
    int burst_left = 0, gap_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                void'(pending_poses.pop_front());
            end
            if (i_valid && o_stall) begin
                // hold payload
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_valid <= 1'b0;
            end else if (pending_poses.size() > (i_valid && !o_stall ? 0 : 0) &&
                         pending_poses.size() > 0) begin
                pose_t p;
                p = pending_poses[0];
                i_valid <= 1'b1;
                i_pos_x <= p.pos[0]; i_pos_y <= p.pos[1]; i_pos_z <= p.pos[2];
                i_scl_x <= p.scl[0]; i_scl_y <= p.scl[1]; i_scl_z <= p.scl[2];
                i_angle_x <= p.ang[0]; i_angle_y <= p.ang[1];
                i_angle_z <= p.ang[2];
                predict_matrix(p);
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern with one long hold-off
    int stall_phase = 0;
    int hold_left = 0;
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (stall_phase == 600) begin
            hold_left <= 300;
            i_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall <= 1'b1;
        end else if (stall_phase[8])
            i_stall <= 1'b0;
        else
            i_stall <= ($urandom_range(0, 3) == 0);
    end

    // monitor
    always @(posedge i_clk) begin
        row_t e;
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (o_valid && !i_stall) begin
                if (expected_rows.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected row word: row %0d", o_row_index);
                end else begin
                    e = expected_rows.pop_front();
                    if (o_row_index !== e.row || o_col0 !== e.col[0] ||
                        o_col1 !== e.col[1] || o_col2 !== e.col[2] ||
                        o_col3 !== e.col[3] || o_last_row !== e.last) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch exp %0d %h %h %h %h %b got %0d %h %h %h %h %b",
                                     e.row, e.col[0], e.col[1], e.col[2], e.col[3], e.last,
                                     o_row_index, o_col0, o_col1, o_col2, o_col3, o_last_row);
                    end
                end
            end
            if (idle_cycles >= WDOG) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic add_pose(logic signed [31:0] px, py, pz, sx, sy, sz,
                            logic signed [15:0] ax, ay, az);
        pose_t p;
        p.pos = '{px, py, pz};
        p.scl = '{sx, sy, sz};
        p.ang = '{ax, ay, az};
        pending_poses.push_back(p);
    endtask

    initial begin
        logic signed [31:0] one, mx, mn;
        one = 32'sh10000;
        mx = 32'sh7fffffff;
        mn = 32'sh80000000;
        add_pose(0, 0, 0, one, one, one, 0, 0, 0);
        add_pose(mx, mn, -1, mx, mx, mx, 16'sh7fff, 16'sh8000, 0);
        add_pose(mn, mx, 1, mn, mn, mn, 16'sh8000, 16'sh7fff, 16'sh7fff);
        add_pose(one, -one, 0, one, -one, 2 * one, 5760, 11520, 17280);
        add_pose(1, 2, 3, one, one, one, 23040, -23040, -5760);
        add_pose(0, 0, 0, mx, mn, one, 2880, -2880, 8640);
        add_pose(-1, -1, -1, -one, -one, -one, 23039, -1, 1);
        add_pose(5, 6, 7, 0, 0, 0, 5759, 5761, 11519);
        add_pose(mx, mx, mx, mn, mx, mn, -17280, -11520, 22000);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int n = 0; n < 200; n++) begin
            add_pose(rand_q16(), rand_q16(), rand_q16(), rand_q16(), rand_q16(),
                     rand_q16(), rand_angle(), rand_angle(), rand_angle());
        end
        wait (pending_poses.size() == 0 && !i_valid);
        wait (expected_rows.size() == 0);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && expected_rows.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> filelist.f
rtl/mmb_pkg.sv
rtl/mmb_sincos.sv
rtl/model_matrix_builder_top.sv
dv/tb_model_matrix_builder_top.sv
